FILE: sv/rc4_pkg.sv
// rc4_pkg: shared types and constants for the rc4 stream cipher block
// no dependencies; compiled first

package rc4_pkg;

   localparam int BYTE_W     = 8;
   localparam int PERM_DEPTH = 256;
   localparam int PERM_AW    = 8;
   localparam int CFG_W      = 9;

   // beat kind codes
   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_TEXT = 1'b1;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic     kind;
      byte_type value;
   } req_payload_type;

   typedef struct packed {
      byte_type out_byte;
      byte_type keystream_byte;
   } rsp_payload_type;

   // access controls for the permutation store
   typedef struct packed {
      logic               clear;
      logic               rd_en;
      logic [PERM_AW-1:0] rd_addr;
      logic               wr_en;
      logic [PERM_AW-1:0] wr_addr;
      byte_type           wr_data;
   } perm_ctl_type;

endpackage

FILE: sv/rc4_chan_if.sv
// rc4_chan_if: valid/ready channel carrying one payload beat
// payload type given by the instantiating level (rc4_pkg types)

interface rc4_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/rc4_ram.sv
// rc4_ram: generic simple dual-port ram, one write and one registered read
// no dependencies

module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, and read of the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/rc4_perm_store.sv
// rc4_perm_store: 256-entry permutation memory, identity where not written
// depends on rc4_pkg and rc4_ram

module rc4_perm_store (
   input  logic                  clock,
   input  logic                  reset,
   input  rc4_pkg::perm_ctl_type ctl,
   output rc4_pkg::byte_type     rd_data
);
   import rc4_pkg::*;

   logic [PERM_DEPTH-1:0] valid_ff;
   logic [PERM_DEPTH-1:0] valid_in;
   logic [PERM_AW-1:0]    addr_ff;
   logic                  hit_ff;
   logic                  hit_in;
   logic                  byp_ff;
   logic                  byp_in;
   byte_type              byp_data_ff;
   byte_type              ram_q;

   rc4_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(PERM_DEPTH)
   ) perm_ram (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (ctl.wr_addr),
      .wr_data (ctl.wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (ctl.rd_addr),
      .rd_data (ram_q)
   );

   // per-entry written flags; clear restores the identity of every entry
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
   end

   // same-cycle write to the read address is forwarded
   assign byp_in = ctl.wr_en && (ctl.wr_addr == ctl.rd_addr);
   assign hit_in = valid_ff[ctl.rd_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.rd_en) begin
            hit_ff <= hit_in;
            byp_ff <= byp_in;
         end
      end
   end

   // read address and forward data
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         addr_ff     <= ctl.rd_addr;
         byp_data_ff <= ctl.wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : (hit_ff ? ram_q : addr_ff);

   // checks
   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |-> !ctl.rd_en && !ctl.wr_en)
      else $error("permutation clear overlaps an access");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> valid_ff == '0)
      else $error("written flags not cleared");

   a_bypass_src: assert property (@(posedge clock) disable iff (reset)
      (ctl.rd_en && byp_in) |=> byp_ff)
      else $error("read-during-write not forwarded");
endmodule

FILE: sv/rc4_stream_cipher.sv
// rc4_stream_cipher: rc4 key load, key schedule and keystream generation
// depends on rc4_pkg, rc4_chan_if, rc4_ram and rc4_perm_store
//
//   channel   dir  payload                        handshake
//   req_chan  in   kind, value                    valid/ready
//   rsp_chan  out  out_byte, keystream_byte       valid/ready
//   csr       in   key_length (9 bits)            csr_we, no wait
//
// a text beat reads s[i] as it is taken, then reads s[j], then does the
// first swap write and the keystream read; the next beat is taken while
// the second swap write and the result register load happen. these steps
// come from three dependent reads of the permutation memory. a key beat
// leaves the block ready for the next; the last starts the key schedule
// (clear, then per entry: two reads, a swap), during which no beat is taken.
// reset restores the identity through per-entry written flags, no sweep.
// a result not taken holds the block in its last text step.

module rc4_stream_cipher #(
   parameter int KEY_MAX = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   rc4_chan_if.sink                req_chan,
   rc4_chan_if.source              rsp_chan,
   input  logic                    csr_we,
   input  logic [rc4_pkg::CFG_W-1:0] csr_wdata
);
   import rc4_pkg::*;

   localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int FW  = $clog2(KEY_MAX + 1);
   localparam logic [CFG_W-1:0] KEY_MAX_L = CFG_W'(KEY_MAX);

   typedef enum logic [3:0] {
      S_IDLE,
      S_T1,
      S_T2,
      S_T3,
      S_KCLR,
      S_K0,
      S_K1,
      S_K2
   } state_type;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   key_len_ff, key_len_in;
   logic [FW-1:0]      fill_ff, fill_in;
   byte_type           i_ff, i_in;
   byte_type           j_ff, j_in;
   byte_type           text_ff, text_in;
   byte_type           si_ff, si_in;
   byte_type           t_ff, t_in;
   logic [PERM_AW-1:0] p_ff, p_in;
   byte_type           acc_ff, acc_in;
   logic [KAW-1:0]     kidx_ff, kidx_in;
   logic               pend_we_ff, pend_we_in;
   logic [PERM_AW-1:0] pend_addr_ff, pend_addr_in;
   byte_type           pend_data_ff, pend_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic [CFG_W-1:0]   len_eff;
   logic [FW-1:0]      fill_cur;
   logic [FW-1:0]      fill_next;
   logic               slot_free;
   logic               req_ready;
   logic               accept;
   logic               key_we;
   logic               key_re;
   byte_type           key_rd;
   byte_type           perm_rd;
   byte_type           ks;
   perm_ctl_type       ctl;

   rc4_perm_store perm_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_data (perm_rd)
   );

   rc4_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(KEY_MAX)
   ) key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (KAW'(fill_cur)),
      .wr_data (req_chan.payload.value),
      .rd_en   (key_re),
      .rd_addr (kidx_ff),
      .rd_data (key_rd)
   );

   // key length clamped to 1..KEY_MAX
   always_comb begin
      priority if (key_len_ff == '0) begin
         len_eff = CFG_W'(1);
      end else if (key_len_ff > KEY_MAX_L) begin
         len_eff = KEY_MAX_L;
      end else begin
         len_eff = key_len_ff;
      end
   end

   assign fill_cur  = (CFG_W'(fill_ff) >= len_eff) ? '0 : fill_ff;
   assign fill_next = fill_cur + FW'(1);

   // handshake
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_T3) && slot_free);
   assign accept    = req_chan.valid && req_ready;

   // keystream byte; s[j] is still pending its write-back here
   assign ks = (t_ff == j_ff) ? si_ff : perm_rd;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      key_len_in   = key_len_ff;
      fill_in      = fill_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      text_in      = text_ff;
      si_in        = si_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      acc_in       = acc_ff;
      kidx_in      = kidx_ff;
      pend_we_in   = 1'b0;
      pend_addr_in = pend_addr_ff;
      pend_data_in = pend_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      key_we       = 1'b0;
      key_re       = 1'b0;
      ctl          = '0;

      // second half of a swap, in the cycle after the first
      if (pend_we_ff) begin
         ctl.wr_en   = 1'b1;
         ctl.wr_addr = pend_addr_ff;
         ctl.wr_data = pend_data_ff;
      end

      // register write restarts key loading
      if (csr_we) begin
         key_len_in = csr_wdata;
         fill_in    = '0;
      end

      unique case (state_ff)
         S_IDLE: begin
         end
         S_T1: begin
            si_in       = perm_rd;
            j_in        = j_ff + perm_rd;
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = j_in;
            state_in    = S_T2;
         end
         S_T2: begin
            ctl.wr_en    = 1'b1;
            ctl.wr_addr  = i_ff;
            ctl.wr_data  = perm_rd;
            pend_we_in   = 1'b1;
            pend_addr_in = j_ff;
            pend_data_in = si_ff;
            t_in         = si_ff + perm_rd;
            ctl.rd_en    = 1'b1;
            ctl.rd_addr  = t_in;
            state_in     = S_T3;
         end
         S_T3: begin
            if (slot_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.out_byte       = text_ff ^ ks;
               rsp_data_in.keystream_byte = ks;
               state_in                   = S_IDLE;
            end
         end
         S_KCLR: begin
            ctl.clear = 1'b1;
            p_in      = '0;
            acc_in    = '0;
            kidx_in   = '0;
            i_in      = '0;
            j_in      = '0;
            state_in  = S_K0;
         end
         S_K0: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = p_ff;
            key_re      = 1'b1;
            state_in    = S_K1;
         end
         S_K1: begin
            si_in       = perm_rd;
            acc_in      = acc_ff + perm_rd + key_rd;
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = acc_in;
            state_in    = S_K2;
         end
         S_K2: begin
            ctl.wr_en    = 1'b1;
            ctl.wr_addr  = p_ff;
            ctl.wr_data  = perm_rd;
            pend_we_in   = 1'b1;
            pend_addr_in = acc_ff;
            pend_data_in = si_ff;
            p_in         = p_ff + PERM_AW'(1);
            if ((CFG_W'(kidx_ff) + CFG_W'(1)) == len_eff) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_ff + KAW'(1);
            end
            state_in = (&p_ff) ? S_IDLE : S_K0;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // input beat
      if (accept) begin
         if (req_chan.payload.kind == KIND_TEXT) begin
            text_in     = req_chan.payload.value;
            i_in        = i_ff + BYTE_W'(1);
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = i_in;
            state_in    = S_T1;
         end else begin
            key_we = 1'b1;
            if (CFG_W'(fill_next) >= len_eff) begin
               fill_in  = '0;
               state_in = S_KCLR;
            end else begin
               fill_in = fill_next;
            end
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_len_ff   <= CFG_W'(1);
         fill_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         pend_we_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_len_ff   <= key_len_in;
         fill_ff      <= fill_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         pend_we_ff   <= pend_we_in;
         rsp_valid_ff <= rsp_valid_in;
         text_ff      <= text_in;
         si_ff        <= si_in;
         t_ff         <= t_in;
         p_ff         <= p_in;
         acc_ff       <= acc_in;
         kidx_ff      <= kidx_in;
         pend_addr_ff <= pend_addr_in;
         pend_data_ff <= pend_data_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // checks
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      pend_we_ff |-> !(state_ff == S_T2 || state_ff == S_K2))
      else $error("two permutation writes in one cycle");

   a_swap_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_T2 || state_ff == S_K2) |=> pend_we_ff)
      else $error("swap write-back missing");

   a_sched_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KCLR || state_ff == S_K0 || state_ff == S_K1 ||
       state_ff == S_K2) |-> !req_chan.ready)
      else $error("beat taken during key schedule");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_T3))
      else $error("result raised outside the keystream step");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CFG_W'(fill_ff) < len_eff)
      else $error("key fill position beyond key length");
endmodule
